// File: sv/window_viewport_point_mapper_macros.svh
// Assertion macros for the window/viewport point mapper checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef WINDOW_VIEWPORT_POINT_MAPPER_MACROS_SVH
`define WINDOW_VIEWPORT_POINT_MAPPER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define WVPM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define WVPM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/wvpm_pkg.sv
// Shared widths, codes, types and helpers for the window/viewport point mapper.
// No dependencies; every other file but the macros header imports this package.
package wvpm_pkg;

    localparam int COORD_W     = 16;
    localparam int HALF_W      = 16;
    localparam int REG_W       = 2 * HALF_W;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = COORD_W + HALF_W;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STAGES  = (PROD_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W       = DIV_STAGES * DIV_BITS;
    localparam int PRE_STAGES  = 4;
    localparam int POST_STAGES = 2;
    localparam int NSTAGES     = PRE_STAGES + DIV_STAGES + POST_STAGES;
    localparam int DIV_FIRST   = PRE_STAGES;
    localparam int POST_FIRST  = PRE_STAGES + DIV_STAGES;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [HALF_W-1:0]  half_t;
    typedef logic [REG_W-1:0]          reg_t;
    typedef logic [NSTAGES-1:0]        stage_en_t;

    typedef enum logic [1:0] {
        MODE_L2D = 2'd0,
        MODE_L2S = 2'd1,
        MODE_D2L = 2'd2,
        MODE_S2L = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_SCALED_MODE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ORIGIN   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_ORIGIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_EXTENT   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_EXTENT = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ORIGIN   = CFG_IDX_W'(5);

    localparam reg_t EXTENT_RESET = {HALF_W'(1), HALF_W'(1)};

    typedef struct packed {
        logic scaled;
        reg_t window_origin;
        reg_t viewport_origin;
        reg_t window_extent;
        reg_t viewport_extent;
        reg_t screen_origin;
    } cfg_t;

    // One axis worth of configuration, already split out of the registers.
    typedef struct packed {
        logic  scaled;
        half_t wo;
        half_t vo;
        half_t we;
        half_t ve;
        half_t so;
    } axis_cfg_t;

    // Per-item context that rides alongside the divider.
    typedef struct packed {
        logic   neg;
        logic   scaled;
        logic   dz;
        logic   scr;
        coord_t d;
        coord_t to_org;
        coord_t so;
    } side_t;

    function automatic half_t reg_half(reg_t r, logic hi);
        return hi ? r[REG_W-1:HALF_W] : r[HALF_W-1:0];
    endfunction

endpackage

// File: sv/wvpm_cfg_regs.sv
// Configuration register file of the point mapper.
// Depends on wvpm_pkg for register codes and the cfg_t bundle.
module wvpm_cfg_regs import wvpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  reg_t                 cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scaled          <= 1'b0;
            cfg_reg.window_origin   <= '0;
            cfg_reg.viewport_origin <= '0;
            cfg_reg.window_extent   <= EXTENT_RESET;
            cfg_reg.viewport_extent <= EXTENT_RESET;
            cfg_reg.screen_origin   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCALED_MODE:     cfg_reg.scaled          <= cfg_data[0];
                REG_WINDOW_ORIGIN:   cfg_reg.window_origin   <= cfg_data;
                REG_VIEWPORT_ORIGIN: cfg_reg.viewport_origin <= cfg_data;
                REG_WINDOW_EXTENT:   cfg_reg.window_extent   <= cfg_data;
                REG_VIEWPORT_EXTENT: cfg_reg.viewport_extent <= cfg_data;
                REG_SCREEN_ORIGIN:   cfg_reg.screen_origin   <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

// File: sv/wvpm_divider.sv
// Pipelined unsigned restoring divider, DIV_BITS quotient bits per stage.
// Depends on wvpm_pkg for widths and the side_t context carried with each item.
module wvpm_divider import wvpm_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [DIV_W-1:0]      dividend,
    input  logic [HALF_W-1:0]     divisor,
    input  side_t                 side_in,
    output logic [DIV_W-1:0]      quotient,
    output side_t                 side_out
);

    logic [HALF_W-1:0] rem_reg  [DIV_STAGES];
    logic [DIV_W-1:0]  quo_reg  [DIV_STAGES];
    logic [HALF_W-1:0] dvs_reg  [DIV_STAGES];
    side_t             side_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [HALF_W-1:0] rem_in;
        logic [HALF_W-1:0] rem_next;
        logic [DIV_W-1:0]  quo_in;
        logic [DIV_W-1:0]  quo_next;
        logic [HALF_W-1:0] dvs_in;
        side_t             side_s;

        if (s == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = dividend;
            assign dvs_in = divisor;
            assign side_s = side_in;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
            assign side_s = side_reg[s-1];
        end

        // Quotient bits shift in at the bottom while dividend bits leave the top.
        always_comb
        begin
            logic [HALF_W:0] trial;
            rem_next = rem_in;
            quo_next = quo_in;
            trial    = '0;
            for (int b = 0; b < DIV_BITS; b++)
            begin
                trial    = {rem_next, quo_next[DIV_W-1]};
                quo_next = {quo_next[DIV_W-2:0], 1'b0};
                if (trial >= {1'b0, dvs_in})
                begin
                    trial       = trial - {1'b0, dvs_in};
                    quo_next[0] = 1'b1;
                end
                rem_next = trial[HALF_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                dvs_reg[s]  <= dvs_in;
                side_reg[s] <= side_s;
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule

// File: sv/wvpm_axis.sv
// One coordinate lane: origin shifts, scale multiply, divide and final offsets.
// Depends on wvpm_pkg and instantiates wvpm_divider.
module wvpm_axis import wvpm_pkg::*;
(
    input  logic      clk,
    input  stage_en_t en,
    input  axis_cfg_t acfg,
    input  mode_t     mode,
    input  coord_t    point,
    output coord_t    mapped,
    output logic      dz
);

    typedef struct packed {
        coord_t val;
        coord_t from_org;
        coord_t to_org;
        half_t  from_ext;
        half_t  to_ext;
        logic   scr;
        logic   scaled;
        coord_t so;
    } pre_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        half_t                    from_ext;
        side_t                    side;
    } mul_t;

    pre_t              s0_next, s0_reg;
    pre_t              s1_next, s1_reg;
    mul_t              s2_next, s2_reg;
    logic [DIV_W-1:0]  dvd_next, dvd_reg;
    logic [HALF_W-1:0] dvs_next, dvs_reg;
    side_t             s3_next, s3_reg;
    logic [DIV_W-1:0]  quo;
    side_t             qside;
    coord_t            v_next, v_reg;
    logic              scr_reg, dz4_reg;
    coord_t            so4_reg;
    coord_t            mapped_next, mapped_reg;
    logic              dz_reg;

    // Stage 0: screen offset on the way in, pick direction of origins and extents.
    always_comb
    begin
        coord_t so_c;
        so_c           = COORD_W'($signed(acfg.so));
        s0_next.so     = so_c;
        s0_next.scr    = (mode == MODE_L2S);
        s0_next.scaled = acfg.scaled;
        s0_next.val    = (mode == MODE_S2L) ? coord_t'(point - so_c) : point;
        if (mode == MODE_L2D || mode == MODE_L2S)
        begin
            s0_next.from_org = COORD_W'($signed(acfg.wo));
            s0_next.to_org   = COORD_W'($signed(acfg.vo));
            s0_next.from_ext = acfg.we;
            s0_next.to_ext   = acfg.ve;
        end
        else
        begin
            s0_next.from_org = COORD_W'($signed(acfg.vo));
            s0_next.to_org   = COORD_W'($signed(acfg.wo));
            s0_next.from_ext = acfg.ve;
            s0_next.to_ext   = acfg.we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_reg <= s0_next;
        end
    end

    // Stage 1: offset from the source origin.
    always_comb
    begin
        s1_next     = s0_reg;
        s1_next.val = coord_t'(s0_reg.val - s0_reg.from_org);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: exact signed product with the target extent.
    always_comb
    begin
        logic signed [PROD_W-1:0] mul_a;
        logic signed [PROD_W-1:0] mul_b;
        mul_a                = PROD_W'($signed(s1_reg.val));
        mul_b                = PROD_W'($signed(s1_reg.to_ext));
        s2_next.prod         = mul_a * mul_b;
        s2_next.from_ext     = s1_reg.from_ext;
        s2_next.side.neg     = 1'b0;
        s2_next.side.scaled  = s1_reg.scaled;
        s2_next.side.dz      = s1_reg.scaled && (s1_reg.from_ext == '0);
        s2_next.side.scr     = s1_reg.scr;
        s2_next.side.d       = s1_reg.val;
        s2_next.side.to_org  = s1_reg.to_org;
        s2_next.side.so      = s1_reg.so;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_reg <= s2_next;
        end
    end

    // Stage 3: magnitudes and quotient sign for the unsigned divider.
    always_comb
    begin
        logic                     prod_neg;
        logic                     ext_neg;
        logic signed [PROD_W-1:0] prod_abs;
        prod_neg    = s2_reg.prod[PROD_W-1];
        ext_neg     = s2_reg.from_ext[HALF_W-1];
        prod_abs    = prod_neg ? -s2_reg.prod : s2_reg.prod;
        dvd_next    = DIV_W'(unsigned'(prod_abs));
        dvs_next    = ext_neg ? HALF_W'(-s2_reg.from_ext) : HALF_W'(s2_reg.from_ext);
        s3_next     = s2_reg.side;
        s3_next.neg = prod_neg ^ ext_neg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            dvd_reg <= dvd_next;
            dvs_reg <= dvs_next;
            s3_reg  <= s3_next;
        end
    end

    wvpm_divider u_div
    (
        .clk      (clk),
        .en       (en[DIV_FIRST +: DIV_STAGES]),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .side_in  (s3_reg),
        .quotient (quo),
        .side_out (qside)
    );

    // Post stage A: apply sign and target origin, zero for a zero divisor, or plain shift in text mode.
    always_comb
    begin
        coord_t qlo;
        qlo = coord_t'(quo[COORD_W-1:0]);
        if (!qside.scaled)
        begin
            v_next = coord_t'(qside.d + qside.to_org);
        end
        else if (qside.dz)
        begin
            v_next = '0;
        end
        else if (qside.neg)
        begin
            v_next = coord_t'(qside.to_org - qlo);
        end
        else
        begin
            v_next = coord_t'(qside.to_org + qlo);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[POST_FIRST])
        begin
            v_reg   <= v_next;
            scr_reg <= qside.scr;
            dz4_reg <= qside.dz;
            so4_reg <= qside.so;
        end
    end

    // Post stage B: screen offset on the way out, skipped for a zero divisor.
    assign mapped_next = (scr_reg && !dz4_reg) ? coord_t'(v_reg + so4_reg) : v_reg;

    always_ff @(posedge clk)
    begin
        if (en[POST_FIRST+1])
        begin
            mapped_reg <= mapped_next;
            dz_reg     <= dz4_reg;
        end
    end

    assign mapped = mapped_reg;
    assign dz     = dz_reg;

endmodule

// File: sv/window_viewport_point_mapper.sv
// Window/viewport point mapper: one point in per cycle, one mapped point out.
// The stages are four front stages, eight divider stages
// retiring four quotient bits each, two output stages. Throughput is one point
// per cycle; a stall freezes only the full stages behind the output.
// Reset clears the stage valid bits and loads the register reset values;
// there is no clearing pass.
module window_viewport_point_mapper import wvpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  reg_t                 cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mode_t                mode,
    input  coord_t               point_x,
    input  coord_t               point_y,
    input  logic                 last_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output coord_t               mapped_x,
    output coord_t               mapped_y,
    output logic                 divide_by_zero,
    output logic                 last_out
);

    cfg_t           cfg;
    axis_cfg_t      acfg_x, acfg_y;
    logic [NSTAGES:0] ready_c;
    stage_en_t      valid_reg, last_reg;
    stage_en_t      valid_next, last_next;
    logic           dz_x, dz_y;

    wvpm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        acfg_x.scaled = cfg.scaled;
        acfg_x.wo     = reg_half(cfg.window_origin, 1'b0);
        acfg_x.vo     = reg_half(cfg.viewport_origin, 1'b0);
        acfg_x.we     = reg_half(cfg.window_extent, 1'b0);
        acfg_x.ve     = reg_half(cfg.viewport_extent, 1'b0);
        acfg_x.so     = reg_half(cfg.screen_origin, 1'b0);
        acfg_y.scaled = cfg.scaled;
        acfg_y.wo     = reg_half(cfg.window_origin, 1'b1);
        acfg_y.vo     = reg_half(cfg.viewport_origin, 1'b1);
        acfg_y.we     = reg_half(cfg.window_extent, 1'b1);
        acfg_y.ve     = reg_half(cfg.viewport_extent, 1'b1);
        acfg_y.so     = reg_half(cfg.screen_origin, 1'b1);
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        ready_c[NSTAGES] = out_ready;
        for (int k = NSTAGES - 1; k >= 0; k--)
        begin
            ready_c[k] = !valid_reg[k] || ready_c[k+1];
        end
    end

    assign valid_next = {valid_reg[NSTAGES-2:0], in_valid};
    assign last_next  = {last_reg[NSTAGES-2:0], last_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGES; k++)
            begin
                if (ready_c[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NSTAGES; k++)
        begin
            if (ready_c[k])
            begin
                last_reg[k] <= last_next[k];
            end
        end
    end

    wvpm_axis u_axis_x
    (
        .clk    (clk),
        .en     (ready_c[NSTAGES-1:0]),
        .acfg   (acfg_x),
        .mode   (mode),
        .point  (point_x),
        .mapped (mapped_x),
        .dz     (dz_x)
    );

    wvpm_axis u_axis_y
    (
        .clk    (clk),
        .en     (ready_c[NSTAGES-1:0]),
        .acfg   (acfg_y),
        .mode   (mode),
        .point  (point_y),
        .mapped (mapped_y),
        .dz     (dz_y)
    );

    assign in_ready       = ready_c[0];
    assign out_valid      = valid_reg[NSTAGES-1];
    assign last_out       = last_reg[NSTAGES-1];
    assign divide_by_zero = dz_x | dz_y;

endmodule

// File: sv/wvpm_checker.sv
// Port-level checker for the point mapper, bound to the top level.
// Depends on wvpm_pkg and the assertion macros header.
`include "window_viewport_point_mapper_macros.svh"

module wvpm_checker import wvpm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input reg_t                 cfg_data,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input coord_t               mapped_x,
    input coord_t               mapped_y,
    input logic                 divide_by_zero,
    input logic                 last_out
);

    localparam int CNT_W = $clog2(NSTAGES + 2);

    logic [CNT_W-1:0] inflight_reg;
    logic             scaled_reg;
    logic             in_beat, out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Track beats in flight and the scaling switch as seen on the ports.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            scaled_reg   <= 1'b0;
        end
        else
        begin
            if (in_beat && !out_beat)
            begin
                inflight_reg <= inflight_reg + CNT_W'(1);
            end
            else if (out_beat && !in_beat)
            begin
                inflight_reg <= inflight_reg - CNT_W'(1);
            end
            if (cfg_valid && cfg_ready && cfg_index == REG_SCALED_MODE)
            begin
                scaled_reg <= cfg_data[0];
            end
        end
    end

    `WVPM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mapped_x) && $stable(mapped_y) && $stable(divide_by_zero) && $stable(last_out), "stalled result changed")
    `WVPM_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready, "input blocked with output empty")
    `WVPM_ASSERT_IMP(a_no_invented, out_valid, inflight_reg != '0, "result with no beat in flight")
    `WVPM_ASSERT_IMP(a_depth, 1'b1, inflight_reg <= CNT_W'(NSTAGES), "more beats in flight than stages")
    `WVPM_ASSERT_IMP(a_text_no_dz, out_valid && !scaled_reg, !divide_by_zero, "zero divisor flag in text mode")

endmodule

bind window_viewport_point_mapper wvpm_checker u_checker (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for window_viewport_point_mapper: directed table, then random traffic.
// Uses wvpm_pkg for port types, mode names and register indexes; predicts each mapped point the table does not give.
module tb_top;
    import wvpm_pkg::*;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   dz;
        logic   last;
    } point_result_t;

    typedef struct packed {
        bit   scaled;
        reg_t wo;
        reg_t vo;
        reg_t we;
        reg_t ve;
        reg_t so;
    } map_setting_t;

    typedef struct packed {
        int            setting;
        mode_t         m;
        coord_t        x;
        coord_t        y;
        logic          last;
        logic          typed;
        point_result_t want;
    } probe_t;

    localparam int     ROWS = 24;
    localparam int     PHASES = 4;
    localparam int     BLOCKS_PER_PHASE = 5;
    localparam int     POINTS_PER_BLOCK = 60;
    localparam coord_t EDGE_COORDS [5] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};

    localparam int SENDER_IDLE [PHASES] = '{0, 88, 0, 25};
    localparam int RECV_STALL  [PHASES] = '{0, 0, 88, 25};

    localparam map_setting_t DIRECTED_SETTINGS [5] = '{
        '{1'b0, 32'h0, 32'h0, EXTENT_RESET, EXTENT_RESET, 32'h0},
        // x divisor zero going logical to device, zero target on the way back
        '{1'b1, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0001, 32'h0005_0003},
        // every divisor zero
        '{1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0005_0003},
        '{1'b1, 32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_7FFF, 32'h7FFF_8000, 32'hFFFF_8000},
        // text mapping ignores zero extents
        '{1'b0, 32'h1234_8001, 32'hFFFE_7FFF, 32'h0, 32'h0, 32'h0100_FF00}
    };

    localparam point_result_t NO_CHECK = '{16'sd0, 16'sd0, 1'b0, 1'b0};

    localparam probe_t PROBES [ROWS] = '{
        '{0, MODE_L2D, 16'sd0, 16'sd0, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
        '{0, MODE_L2D, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0}},
        '{0, MODE_L2S, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1, '{16'sh8000, 16'sh7FFF, 1'b0, 1'b0}},
        '{0, MODE_D2L, -16'sd1, 16'sd1, 1'b0, 1'b1, '{-16'sd1, 16'sd1, 1'b0, 1'b0}},
        '{0, MODE_S2L, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0}},
        '{0, MODE_S2L, 16'sh8000, 16'sh8000, 1'b0, 1'b1, '{16'sh8000, 16'sh8000, 1'b0, 1'b0}},
        '{1, MODE_L2D, 16'sd1234, -16'sd1234, 1'b0, 1'b1, '{16'sd0, -16'sd1234, 1'b1, 1'b0}},
        '{1, MODE_L2S, 16'sd100, 16'sd200, 1'b0, 1'b1, '{16'sd0, 16'sd205, 1'b1, 1'b0}},
        '{1, MODE_D2L, 16'sd7, -16'sd7, 1'b0, 1'b1, '{16'sd0, -16'sd7, 1'b0, 1'b0}},
        '{1, MODE_S2L, 16'sd10, 16'sd10, 1'b0, 1'b1, '{16'sd0, 16'sd5, 1'b0, 1'b0}},
        '{1, MODE_L2D, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1, '{16'sd0, 16'sh8000, 1'b1, 1'b0}},
        '{2, MODE_L2D, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{2, MODE_L2S, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{2, MODE_D2L, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{2, MODE_S2L, 16'sh8000, 16'sh7FFF, 1'b1, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{3, MODE_L2D, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, NO_CHECK},
        '{3, MODE_L2S, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0, NO_CHECK},
        '{3, MODE_D2L, 16'sd0, -16'sd1, 1'b1, 1'b0, NO_CHECK},
        '{3, MODE_S2L, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, NO_CHECK},
        '{3, MODE_D2L, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0, NO_CHECK},
        '{4, MODE_L2D, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0, NO_CHECK},
        '{4, MODE_L2S, 16'sd1, 16'sd1, 1'b0, 1'b0, NO_CHECK},
        '{4, MODE_S2L, -16'sd1, 16'sh8000, 1'b0, 1'b0, NO_CHECK},
        '{4, MODE_D2L, 16'sh7FFF, 16'sd0, 1'b1, 1'b0, NO_CHECK}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    reg_t                 cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    mode_t                mode;
    coord_t               point_x;
    coord_t               point_y;
    logic                 last_in;
    logic                 out_valid;
    logic                 out_ready;
    coord_t               mapped_x;
    coord_t               mapped_y;
    logic                 divide_by_zero;
    logic                 last_out;

    // predictor copy of the register file, indexed by register number
    reg_t          map_regs [REG_SCREEN_ORIGIN+1];
    point_result_t expected_points [$];
    point_result_t typed_result;
    logic          use_typed;
    point_result_t got_point;
    int            idle_pct;
    int            stall_pct;
    int            errors;
    int            points_sent;
    int            points_checked;
    int            dz_seen;
    int            settings_applied;

    window_viewport_point_mapper DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .point_x        (point_x),
        .point_y        (point_y),
        .last_in        (last_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mapped_x       (mapped_x),
        .mapped_y       (mapped_y),
        .divide_by_zero (divide_by_zero),
        .last_out       (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout at %0t with %0d points outstanding", $time, expected_points.size());
        $display("window_viewport_point_mapper: mismatch");
        $finish;
    end

    // Map one axis: shift by origins, and in scaled mode scale by to/from extents.
    function automatic coord_t scale_axis(input coord_t p, input coord_t from_org,
                                          input coord_t to_org, input coord_t from_ext,
                                          input coord_t to_ext, input bit scaled,
                                          output bit dz);
        coord_t d;
        longint prod;
        dz = 1'b0;
        d = p - from_org;
        if (!scaled)
            return d + to_org;
        if (from_ext == 16'sd0)
        begin
            dz = 1'b1;
            return 16'sd0;
        end
        prod = longint'(d) * longint'(to_ext);
        return coord_t'(prod / longint'(from_ext) + longint'(to_org));
    endfunction

    function automatic point_result_t predict_point(input mode_t m, input coord_t x,
                                                    input coord_t y, input logic last);
        point_result_t r;
        coord_t        p;
        coord_t        q;
        coord_t        v;
        coord_t        wo;
        coord_t        vo;
        coord_t        we;
        coord_t        ve;
        coord_t        so;
        bit            axis_dz;
        bit            sc;
        sc = map_regs[REG_SCALED_MODE][0];
        r.dz = 1'b0;
        r.last = last;
        r.x = '0;
        r.y = '0;
        for (int a = 0; a < 2; a++)
        begin
            p  = a ? y : x;
            wo = map_regs[REG_WINDOW_ORIGIN][a*HALF_W +: HALF_W];
            vo = map_regs[REG_VIEWPORT_ORIGIN][a*HALF_W +: HALF_W];
            we = map_regs[REG_WINDOW_EXTENT][a*HALF_W +: HALF_W];
            ve = map_regs[REG_VIEWPORT_EXTENT][a*HALF_W +: HALF_W];
            so = map_regs[REG_SCREEN_ORIGIN][a*HALF_W +: HALF_W];
            if (m == MODE_L2D || m == MODE_L2S)
            begin
                v = scale_axis(p, wo, vo, we, ve, sc, axis_dz);
                // screen offset is skipped on an axis that hit a zero divisor
                if (m == MODE_L2S && !axis_dz)
                    v = v + so;
            end
            else
            begin
                q = (m == MODE_S2L) ? coord_t'(p - so) : p;
                v = scale_axis(q, vo, wo, ve, we, sc, axis_dz);
            end
            if (axis_dz)
                r.dz = 1'b1;
            if (a == 1)
                r.y = v;
            else
                r.x = v;
        end
        return r;
    endfunction

    function automatic half_t rand_half();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return half_t'($urandom_range(0, 32)) - half_t'(16);
            2: return EDGE_COORDS[$urandom_range(0, 4)];
            default: return half_t'($urandom());
        endcase
    endfunction

    function automatic coord_t rand_coord();
        if ($urandom_range(0, 3) == 0)
            return EDGE_COORDS[$urandom_range(0, 4)];
        return coord_t'($urandom());
    endfunction

    function automatic map_setting_t rand_setting();
        map_setting_t s;
        s.scaled = ($urandom_range(0, 3) != 0);
        s.wo = {rand_half(), rand_half()};
        s.vo = {rand_half(), rand_half()};
        s.we = {rand_half(), rand_half()};
        s.ve = {rand_half(), rand_half()};
        s.so = {rand_half(), rand_half()};
        return s;
    endfunction

    // Leaves cfg_valid high; the caller drops it after the last beat.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input reg_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= REG_SCREEN_ORIGIN)
            map_regs[idx] = data;
    endtask

    // Drain the pipe, then load all six registers plus one write to an unmapped index.
    task automatic apply_settings(input map_setting_t s);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        cfg_write(REG_SCALED_MODE, ($urandom() & ~32'h1) | reg_t'(s.scaled));
        cfg_write(REG_WINDOW_ORIGIN, s.wo);
        cfg_write(REG_VIEWPORT_ORIGIN, s.vo);
        cfg_write(CFG_IDX_W'(REG_SCREEN_ORIGIN + 1 + $urandom_range(0, 1)), $urandom());
        cfg_write(REG_WINDOW_EXTENT, s.we);
        cfg_write(REG_VIEWPORT_EXTENT, s.ve);
        cfg_write(REG_SCREEN_ORIGIN, s.so);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Leaves in_valid high after the beat; the next call or the caller decides.
    task automatic send_point(input mode_t m, input coord_t x, input coord_t y,
                              input logic last, input logic typed,
                              input point_result_t want);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        point_x      <= x;
        point_y      <= y;
        last_in      <= last;
        use_typed    <= typed;
        typed_result <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        points_sent++;
    endtask

    task automatic check_field(input string what, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Record each accepted point, then check each result beat against the oldest one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (use_typed)
                    expected_points.push_back(typed_result);
                else
                    expected_points.push_back(predict_point(mode, point_x, point_y, last_in));
            end
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result expected none actual x=%0d y=%0d",
                             $time, mapped_x, mapped_y);
                end
                else
                begin
                    got_point = expected_points.pop_front();
                    check_field("mapped_x", got_point.x, mapped_x);
                    check_field("mapped_y", got_point.y, mapped_y);
                    check_field("divide_by_zero", 16'(got_point.dz), 16'(divide_by_zero));
                    check_field("last_out", 16'(got_point.last), 16'(last_out));
                    points_checked++;
                    if (divide_by_zero === 1'b1)
                        dz_seen++;
                end
            end
        end
    end

    initial
    begin
        int            cur_setting;
        point_result_t want;
        errors = 0;
        points_sent = 0;
        points_checked = 0;
        dz_seen = 0;
        settings_applied = 0;
        idle_pct = 0;
        stall_pct = 0;
        map_regs[REG_SCALED_MODE]     = '0;
        map_regs[REG_WINDOW_ORIGIN]   = '0;
        map_regs[REG_VIEWPORT_ORIGIN] = '0;
        map_regs[REG_WINDOW_EXTENT]   = EXTENT_RESET;
        map_regs[REG_VIEWPORT_EXTENT] = EXTENT_RESET;
        map_regs[REG_SCREEN_ORIGIN]   = '0;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        mode         <= MODE_L2D;
        point_x      <= '0;
        point_y      <= '0;
        last_in      <= 1'b0;
        out_ready    <= 1'b0;
        use_typed    <= 1'b0;
        typed_result <= NO_CHECK;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the first rows run on the reset register values
        cur_setting = 0;
        for (int i = 0; i < ROWS; i++)
        begin
            if (PROBES[i].setting != cur_setting)
            begin
                apply_settings(DIRECTED_SETTINGS[PROBES[i].setting]);
                cur_setting = PROBES[i].setting;
            end
            want = PROBES[i].want;
            want.last = PROBES[i].last;
            send_point(PROBES[i].m, PROBES[i].x, PROBES[i].y, PROBES[i].last,
                       PROBES[i].typed, want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_pct  = SENDER_IDLE[ph];
            stall_pct = RECV_STALL[ph];
            for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++)
            begin
                apply_settings(rand_setting());
                for (int n = 0; n < POINTS_PER_BLOCK; n++)
                    send_point(mode_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                               logic'($urandom_range(0, 1)), 1'b0, NO_CHECK);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        // hold a little longer to catch stray result beats
        repeat (2 * NSTAGES) @(posedge clk);

        $display("sent %0d points over %0d register settings and four handshake phases",
                 points_sent, settings_applied);
        $display("checked %0d mapped points, %0d of them flagged a zero divisor",
                 points_checked, dz_seen);
        if (errors == 0)
            $display("window_viewport_point_mapper: match");
        else
            $display("window_viewport_point_mapper: mismatch");
        $finish;
    end
endmodule
